// ===== design/fcth_pkg.sv =====
// ---------------------------------------------------------------------------
// fcth_pkg: shared definitions for the framed command threshold parser
// Character codes, the PCTH type word, defaults and the field control struct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcth_pkg;

  localparam int MAX_TYPE_CHARS_DEF    = 6;
  localparam int MAX_PAYLOAD_CHARS_DEF = 100;
  localparam int VALUE_BITS_DEF        = 16;

  localparam int TYPE_LEN_W    = 3;
  localparam int PAYLOAD_LEN_W = 7;
  localparam int THRESH_W      = 16;

  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CHAR_END   = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam int PCTH_LEN = 4;
  localparam logic [7:0] PCTH_WORD [PCTH_LEN] = '{8'h50, 8'h43, 8'h54, 8'h48};

  localparam int LOWER_LIMIT_RST = 25;
  localparam int UPPER_LIMIT_RST = 70;

  // field numbers
  localparam logic [1:0] FIELD_FIRST  = 2'd0;
  localparam logic [1:0] FIELD_SECOND = 2'd1;
  localparam logic [1:0] FIELD_DONE   = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_TYPE    = 3'b010,
    PH_PAYLOAD = 3'b100
  } fcth_phase_e;

  typedef struct packed {
    logic clear;  // new payload begins
    logic take;   // payload byte consumed into the fields
    logic close;  // frame closed by '*'
  } fcth_fld_ctrl_t;

endpackage

`default_nettype wire

// ===== design/fcth_field_conv.sv =====
// ---------------------------------------------------------------------------
// fcth_field_conv: payload field converter
// Turns the first two comma-separated payload fields into wrapping integers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcth_field_conv #(
  parameter int VALUE_BITS = fcth_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire fcth_pkg::fcth_fld_ctrl_t    ctrl_i,
  input  wire logic [7:0]                  byte_i,
  output logic      [VALUE_BITS-1:0]       first_o,
  output logic      [VALUE_BITS-1:0]       second_o
);
  import fcth_pkg::*;

  logic [1:0]            field_q, field_d;
  logic                  at_start_q, at_start_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] first_q, first_d;
  logic [VALUE_BITS-1:0] second_q, second_d;

  logic                  active;
  logic [VALUE_BITS-1:0] cur_val;
  logic [VALUE_BITS-1:0] acc_val;
  logic [VALUE_BITS-1:0] first_fin, second_fin;

  assign active  = (field_q == FIELD_FIRST) || (field_q == FIELD_SECOND);
  assign cur_val = (field_q == FIELD_FIRST) ? first_q : second_q;
  // v*10 + b - '0', all modulo 2^VALUE_BITS
  assign acc_val = (cur_val << 3) + (cur_val << 1) + VALUE_BITS'(byte_i)
                   - VALUE_BITS'(CHAR_ZERO);

  // values with the pending sign applied to the open field
  assign first_fin  = (neg_q && field_q == FIELD_FIRST)  ? (~first_q + 1'b1)  : first_q;
  assign second_fin = (neg_q && field_q == FIELD_SECOND) ? (~second_q + 1'b1) : second_q;

  assign first_o  = first_fin;
  assign second_o = second_fin;

  always_comb begin
    field_d    = field_q;
    at_start_d = at_start_q;
    neg_d      = neg_q;
    first_d    = first_q;
    second_d   = second_q;
    if (ctrl_i.clear) begin
      field_d    = FIELD_FIRST;
      at_start_d = 1'b1;
      neg_d      = 1'b0;
      first_d    = '0;
      second_d   = '0;
    end else if (ctrl_i.close) begin
      if (active) begin
        first_d    = first_fin;
        second_d   = second_fin;
        neg_d      = 1'b0;
        at_start_d = 1'b1;
      end
    end else if (ctrl_i.take && active) begin
      priority if (byte_i == CHAR_NUL || byte_i == CHAR_COMMA) begin
        first_d    = first_fin;
        second_d   = second_fin;
        neg_d      = 1'b0;
        at_start_d = 1'b1;
        field_d    = (byte_i == CHAR_NUL) ? FIELD_DONE : field_q + 2'd1;
      end else if (at_start_q && byte_i == CHAR_MINUS) begin
        neg_d      = 1'b1;
        at_start_d = 1'b0;
      end else if (at_start_q && byte_i == CHAR_PLUS) begin
        at_start_d = 1'b0;
      end else begin
        at_start_d = 1'b0;
        if (field_q == FIELD_FIRST) begin
          first_d = acc_val;
        end else begin
          second_d = acc_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q    <= FIELD_FIRST;
      at_start_q <= 1'b1;
      neg_q      <= 1'b0;
      first_q    <= '0;
      second_q   <= '0;
    end else begin
      field_q    <= field_d;
      at_start_q <= at_start_d;
      neg_q      <= neg_d;
      first_q    <= first_d;
      second_q   <= second_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/framed_command_threshold_parser.sv =====
// ---------------------------------------------------------------------------
// framed_command_threshold_parser: $TYPE,payload* frame parser
// Frames received bytes, converts two payload fields and, on a PCTH frame,
// replaces the stored minimum and maximum thresholds.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, rx_byte_i) takes one byte per
//   cycle while in_ready_o is high. Every byte updates the parser state in
//   the cycle it is accepted. A '*' that closes a frame produces one item
//   on the output channel (out_valid_o / out_ready_i and the result ports);
//   all other bytes produce nothing.
//   Latency: the result appears in the cycle after the '*' is accepted.
//   Throughput: one byte per cycle while in_ready_o is high.
//   The output register holds one item; while it is full and the receiver
//   stalls, in_ready_o drops. When the receiver takes the item in the same
//   cycle, a new byte is still accepted.
//   Reset: parser hunts for '$', thresholds return to 25 and 70, output
//   register empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_command_threshold_parser #(
  parameter int MAX_TYPE_CHARS    = fcth_pkg::MAX_TYPE_CHARS_DEF,
  parameter int MAX_PAYLOAD_CHARS = fcth_pkg::MAX_PAYLOAD_CHARS_DEF,
  parameter int VALUE_BITS        = fcth_pkg::VALUE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             threshold_frame_o,
  output logic [2:0]       type_length_o,
  output logic [6:0]       payload_length_o,
  output logic signed [15:0] min_threshold_o,
  output logic signed [15:0] max_threshold_o
);
  import fcth_pkg::*;

  localparam int TC_W = $clog2(MAX_TYPE_CHARS + 1);
  localparam int PC_W = $clog2(MAX_PAYLOAD_CHARS + 1);

  fcth_phase_e             phase_q, phase_d;
  logic [TC_W-1:0]         type_cnt_q, type_cnt_d;
  logic                    type_match_q, type_match_d;
  logic [PC_W-1:0]         pay_cnt_q, pay_cnt_d;
  logic [VALUE_BITS-1:0]   lower_q, lower_d;
  logic [VALUE_BITS-1:0]   upper_q, upper_d;

  logic                    out_valid_q, out_valid_d;
  logic                    hit_q, hit_d;
  logic [TYPE_LEN_W-1:0]   tlen_q, tlen_d;
  logic [PAYLOAD_LEN_W-1:0] plen_q, plen_d;
  logic [THRESH_W-1:0]     min_q, min_d;
  logic [THRESH_W-1:0]     max_q, max_d;

  logic                    accept;
  fcth_fld_ctrl_t          fld_ctrl;
  logic [VALUE_BITS-1:0]   first_val, second_val;
  logic                    hit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  fcth_field_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_field_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fld_ctrl),
    .byte_i  (rx_byte_i),
    .first_o (first_val),
    .second_o(second_val)
  );

  assign hit = type_match_q && (type_cnt_q == TC_W'(PCTH_LEN));

  always_comb begin
    phase_d      = phase_q;
    type_cnt_d   = type_cnt_q;
    type_match_d = type_match_q;
    pay_cnt_d    = pay_cnt_q;
    lower_d      = lower_q;
    upper_d      = upper_q;
    fld_ctrl     = '0;

    out_valid_d  = out_valid_q && !out_ready_i;
    hit_d        = hit_q;
    tlen_d       = tlen_q;
    plen_d       = plen_q;
    min_d        = min_q;
    max_d        = max_q;

    if (accept) begin
      unique case (phase_q)
        PH_TYPE: begin
          if (rx_byte_i == CHAR_COMMA) begin
            phase_d        = PH_PAYLOAD;
            pay_cnt_d      = '0;
            fld_ctrl.clear = 1'b1;
          end else if (type_cnt_q >= TC_W'(MAX_TYPE_CHARS)) begin
            phase_d    = PH_HUNT;
            type_cnt_d = '0;
          end else begin
            if (type_cnt_q >= TC_W'(PCTH_LEN) ||
                rx_byte_i != PCTH_WORD[type_cnt_q[1:0]]) begin
              type_match_d = 1'b0;
            end
            type_cnt_d = type_cnt_q + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (rx_byte_i == CHAR_END) begin
            phase_d        = PH_HUNT;
            fld_ctrl.close = 1'b1;
            if (hit) begin
              lower_d = first_val;
              upper_d = second_val;
            end
            out_valid_d = 1'b1;
            hit_d       = hit;
            tlen_d      = TYPE_LEN_W'(type_cnt_q);
            plen_d      = PAYLOAD_LEN_W'(pay_cnt_q);
            min_d       = hit ? THRESH_W'($signed(first_val))  : THRESH_W'($signed(lower_q));
            max_d       = hit ? THRESH_W'($signed(second_val)) : THRESH_W'($signed(upper_q));
          end else if (pay_cnt_q >= PC_W'(MAX_PAYLOAD_CHARS)) begin
            phase_d   = PH_HUNT;
            pay_cnt_d = '0;
          end else begin
            fld_ctrl.take = 1'b1;
            pay_cnt_d     = pay_cnt_q + 1'b1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == CHAR_START) begin
            phase_d      = PH_TYPE;
            type_cnt_d   = '0;
            type_match_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      type_cnt_q   <= '0;
      type_match_q <= 1'b0;
      pay_cnt_q    <= '0;
      lower_q      <= VALUE_BITS'(LOWER_LIMIT_RST);
      upper_q      <= VALUE_BITS'(UPPER_LIMIT_RST);
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      type_cnt_q   <= type_cnt_d;
      type_match_q <= type_match_d;
      pay_cnt_q    <= pay_cnt_d;
      lower_q      <= lower_d;
      upper_q      <= upper_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    tlen_q <= tlen_d;
    plen_q <= plen_d;
    min_q  <= min_d;
    max_q  <= max_d;
  end

  assign out_valid_o       = out_valid_q;
  assign threshold_frame_o = hit_q;
  assign type_length_o     = tlen_q;
  assign payload_length_o  = plen_q;
  assign min_threshold_o   = $signed(min_q);
  assign max_threshold_o   = $signed(max_q);

endmodule

`default_nettype wire

// ===== tb/framed_command_threshold_parser_tb.sv =====
// ---------------------------------------------------------------------------
// framed_command_threshold_parser_tb: self-checking bench for the frame parser
// Streams bytes into the parser: first a short hand-written table, then random frames
// ($TYPE,payload*) mixed with line noise and broken frames. A bit-exact model of the parser
// predicts each random frame that closes (the table gives its own results), and every
// result item is compared field by field, in order, with stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_command_threshold_parser_tb;
  import fcth_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 10;
  localparam int TIMEOUT_NS   = 4_000_000;
  localparam logic [15:0] DECIMAL_BASE = 16'd10;

  typedef struct packed {
    logic                            thr;
    logic [TYPE_LEN_W-1:0]           tlen;
    logic [PAYLOAD_LEN_W-1:0]        plen;
    logic signed [THRESH_W-1:0]      lo;
    logic signed [THRESH_W-1:0]      hi;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          has_want;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NIL = '0;
  localparam int N_DIRECTED = 27;

  // hand-written frames; results only where obvious
  stim_row_t directed_rows [N_DIRECTED] = '{
    {8'hFF,      1'b0, NIL},                     // noise while hunting
    {CHAR_NUL,   1'b0, NIL},
    {CHAR_START, 1'b0, NIL}, {"P", 1'b0, NIL}, {"C", 1'b0, NIL},
    {"T", 1'b0, NIL}, {"H", 1'b0, NIL}, {CHAR_COMMA, 1'b0, NIL},
    {CHAR_MINUS, 1'b0, NIL}, {"5", 1'b0, NIL}, {CHAR_COMMA, 1'b0, NIL},
    {CHAR_PLUS, 1'b0, NIL}, {"9", 1'b0, NIL},
    {CHAR_END, 1'b1, 1'b1, 3'd4, 7'd5, -16'sd5, 16'sd9},
    // '$' as a type byte, empty payload: thresholds kept
    {CHAR_START, 1'b0, NIL}, {CHAR_START, 1'b0, NIL}, {CHAR_COMMA, 1'b0, NIL},
    {CHAR_END, 1'b1, 1'b0, 3'd1, 7'd0, -16'sd5, 16'sd9},
    // NUL stops extraction, second field stays 0
    {CHAR_START, 1'b0, NIL}, {"P", 1'b0, NIL}, {"C", 1'b0, NIL},
    {"T", 1'b0, NIL}, {"H", 1'b0, NIL}, {CHAR_COMMA, 1'b0, NIL},
    {"7", 1'b0, NIL}, {CHAR_NUL, 1'b0, NIL},
    {CHAR_END, 1'b1, 1'b1, 3'd4, 7'd2, 16'sd7, 16'sd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic threshold_frame_o;
  logic [2:0] type_length_o;
  logic [6:0] payload_length_o;
  logic signed [15:0] min_threshold_o;
  logic signed [15:0] max_threshold_o;

  // typed expectation travelling with the byte on the input channel
  logic          row_has_want = 1'b0;
  frame_result_t row_want = NIL;

  frame_result_t expected_frames [$];
  logic [7:0]    frame_bytes [$];

  int  errors          = 0;
  int  bytes_parsed    = 0;
  int  frames_seen     = 0;
  int  threshold_loads = 0;
  int  ready_hold      = 0;
  bit  no_idle         = 1'b0;

  // parser model state
  fcth_phase_e     ph          = PH_HUNT;
  logic [2:0]      tlen_cnt    = '0;
  logic            type_ok     = 1'b0;
  logic [6:0]      plen_cnt    = '0;
  logic [1:0]      field_idx   = FIELD_FIRST;
  logic            field_fresh = 1'b1;
  logic            field_neg   = 1'b0;
  logic [15:0]     val_a       = '0;
  logic [15:0]     val_b       = '0;
  logic [15:0]     min_lim     = 16'(LOWER_LIMIT_RST);
  logic [15:0]     max_lim     = 16'(UPPER_LIMIT_RST);

  framed_command_threshold_parser i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .threshold_frame_o (threshold_frame_o),
    .type_length_o     (type_length_o),
    .payload_length_o  (payload_length_o),
    .min_threshold_o   (min_threshold_o),
    .max_threshold_o   (max_threshold_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sign is applied as wrapping negation when a field ends
  function automatic void close_field();
    if (field_neg) begin
      if (field_idx == FIELD_FIRST) val_a = -val_a;
      else if (field_idx == FIELD_SECOND) val_b = -val_b;
    end
    field_neg   = 1'b0;
    field_fresh = 1'b1;
  endfunction

  function automatic void convert_payload_byte(input logic [7:0] b);
    if (field_idx >= FIELD_DONE) return;
    if (b == CHAR_NUL) begin
      close_field();
      field_idx = FIELD_DONE;
    end else if (b == CHAR_COMMA) begin
      close_field();
      field_idx++;
    end else if (field_fresh && b == CHAR_MINUS) begin
      field_neg   = 1'b1;
      field_fresh = 1'b0;
    end else if (field_fresh && b == CHAR_PLUS) begin
      field_fresh = 1'b0;
    end else begin
      // any other byte counts as a digit, even a non-digit
      field_fresh = 1'b0;
      if (field_idx == FIELD_FIRST)
        val_a = val_a * DECIMAL_BASE + {8'h00, b} - {8'h00, CHAR_ZERO};
      else
        val_b = val_b * DECIMAL_BASE + {8'h00, b} - {8'h00, CHAR_ZERO};
    end
  endfunction

  task automatic advance_parser(input logic [7:0] b, output bit closed,
                                output frame_result_t res);
    bit hit;
    closed = 1'b0;
    res    = NIL;
    case (ph)
      PH_TYPE: begin
        if (b == CHAR_COMMA) begin
          ph          = PH_PAYLOAD;
          plen_cnt    = '0;
          field_idx   = FIELD_FIRST;
          field_fresh = 1'b1;
          field_neg   = 1'b0;
          val_a       = '0;
          val_b       = '0;
        end else if (tlen_cnt >= MAX_TYPE_CHARS_DEF) begin
          ph       = PH_HUNT;
          tlen_cnt = '0;
        end else begin
          if (tlen_cnt >= PCTH_LEN || b != PCTH_WORD[tlen_cnt[1:0]]) type_ok = 1'b0;
          tlen_cnt++;
        end
      end
      PH_PAYLOAD: begin
        if (b == CHAR_END) begin
          ph = PH_HUNT;
          if (field_idx < FIELD_DONE) close_field();
          hit = type_ok && tlen_cnt == PCTH_LEN;
          if (hit) begin
            min_lim = val_a;
            max_lim = val_b;
          end
          closed = 1'b1;
          res    = '{thr: hit, tlen: tlen_cnt, plen: plen_cnt, lo: min_lim, hi: max_lim};
        end else if (plen_cnt >= MAX_PAYLOAD_CHARS_DEF) begin
          ph       = PH_HUNT;
          plen_cnt = '0;
        end else begin
          convert_payload_byte(b);
          plen_cnt++;
        end
      end
      default: begin
        ph = PH_HUNT;
        if (b == CHAR_START) begin
          ph       = PH_TYPE;
          tlen_cnt = '0;
          type_ok  = 1'b1;
        end
      end
    endcase
  endtask

  // input side: predict on acceptance; output side: check against the oldest
  always @(posedge clk_i) begin
    bit            closed;
    frame_result_t res;
    frame_result_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (ph != PH_HUNT || rx_byte_i == CHAR_START) bytes_parsed++;
        advance_parser(rx_byte_i, closed, res);
        if (closed) begin
          expected_frames.push_back(row_has_want ? row_want : res);
          if (res.thr) threshold_loads++;
        end
      end
      if (out_valid_o && out_ready_i) begin
        frames_seen++;
        if (expected_frames.size() == 0) begin
          report_mismatch("result item with no frame closed");
        end else begin
          e = expected_frames.pop_front();
          if (threshold_frame_o !== e.thr)
            report_mismatch($sformatf("threshold_frame %b, want %b", threshold_frame_o, e.thr));
          if (type_length_o !== e.tlen)
            report_mismatch($sformatf("type_length %0d, want %0d", type_length_o, e.tlen));
          if (payload_length_o !== e.plen)
            report_mismatch($sformatf("payload_length %0d, want %0d",
                                      payload_length_o, e.plen));
          if (min_threshold_o !== e.lo)
            report_mismatch($sformatf("min_threshold %0d, want %0d", min_threshold_o, e.lo));
          if (max_threshold_o !== e.hi)
            report_mismatch($sformatf("max_threshold %0d, want %0d", max_threshold_o, e.hi));
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    int g;
    if (ready_hold > 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      g = pick_gap();
      out_ready_i <= (g == 0);
      if (g != 0) ready_hold <= g - 1;
    end
  end

  // valid is only lowered when a gap follows, so it never toggles in one step
  task automatic send_item(input logic [7:0] b, input logic has_want,
                           input frame_result_t want);
    int g;
    g = pick_gap();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    row_has_want <= has_want;
    row_want     <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic compose_frame();
    int r, k, n, nf, nd, s;
    frame_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    frame_bytes.push_back(CHAR_START);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      for (int i = 0; i < PCTH_LEN; i++) frame_bytes.push_back(PCTH_WORD[i]);
    end else if (r < 62) begin
      // near misses: a PCTH prefix, then random capital letters (at least one after a full PCTH)
      k = $urandom_range(0, PCTH_LEN);
      for (int i = 0; i < k; i++) frame_bytes.push_back(PCTH_WORD[i]);
      n = $urandom_range((k == PCTH_LEN) ? 1 : 0, MAX_TYPE_CHARS_DEF - k);
      repeat (n) frame_bytes.push_back(8'($urandom_range(65, 90)));
    end else if (r < 92) begin
      n = $urandom_range(0, MAX_TYPE_CHARS_DEF);
      repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(MAX_TYPE_CHARS_DEF + 1, MAX_TYPE_CHARS_DEF + 3);
      repeat (n) frame_bytes.push_back(8'($urandom_range(65, 90)));
    end
    frame_bytes.push_back(CHAR_COMMA);
    if ($urandom_range(0, 39) == 0) begin
      // overlong payload, crosses the limit most of the time
      n = $urandom_range(MAX_PAYLOAD_CHARS_DEF - 5, MAX_PAYLOAD_CHARS_DEF + 10);
      repeat (n)
        frame_bytes.push_back(($urandom_range(0, 7) == 0) ? CHAR_COMMA
                                                          : 8'($urandom_range(48, 57)));
    end else begin
      nf = $urandom_range(0, 3);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) frame_bytes.push_back(CHAR_COMMA);
        s = $urandom_range(0, 3);
        if (s == 0) frame_bytes.push_back(CHAR_MINUS);
        else if (s == 1) frame_bytes.push_back(CHAR_PLUS);
        nd = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
        repeat (nd)
          frame_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(48, 57)));
        if ($urandom_range(0, 11) == 0) frame_bytes.push_back(CHAR_NUL);
      end
    end
    if ($urandom_range(0, 9) != 0) frame_bytes.push_back(CHAR_END);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].rx, directed_rows[i].has_want, directed_rows[i].want);

    while (bytes_parsed < RANDOM_ITEMS + N_DIRECTED) begin
      no_idle = ($urandom_range(0, 4) == 0);
      compose_frame();
      foreach (frame_bytes[i]) send_item(frame_bytes[i], 1'b0, NIL);
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Parsed %0d framing bytes; %0d frames closed, %0d of them PCTH threshold loads.",
             bytes_parsed, frames_seen, threshold_loads);
    if (errors == 0) begin
      $display("framed_command_threshold_parser regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("framed_command_threshold_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout, %0d frames still outstanding", expected_frames.size());
    $display("framed_command_threshold_parser regression: fail");
    $finish;
  end

endmodule
